@@ rtl/core/hkst_pkg.sv @@
package hkst_pkg;

  localparam int TABLE_CAPACITY_DEF = 8;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch op/code, clear flags, idx = 0
    logic clear;       // empty the set
    logic rd_scan;     // read entry at idx
    logic rd_last;     // read last held entry
    logic append;      // store code at the tail if room
    logic move;        // last entry into slot idx, count - 1
    logic set_repeat;  // press hit
    logic next_idx;    // advance scan
  } hkst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_press;
    logic count_zero;
    logic match;
    logic at_last;
  } hkst_status_t;

endpackage

@@ rtl/core/held_key_set_tracker_top.sv @@
// Held key set tracker: a small unordered set of held key codes.
//
// Input beat: op (press / release / clear) and key_code, taken at a rising
// edge where start is high and busy is low. busy stays high until the
// result beat has gone out.
// Result beat: is_repeat, was_held, held_count, valid for exactly one
// cycle while done is high. The receiver cannot stall; it must take it.
//
// Sequence, per op: clear or an unused op goes straight to the done state.
// Press and release scan the held entries in order, each read (READ) and
// then compared (CMP). A press hit sets is_repeat; a press miss, or a
// press to an empty table, appends the code if there is room (APPEND).
// A release hit reads the last entry, moves it into the hit slot (MOVE)
// and sets was_held; a release miss or one on an empty set does nothing.
// After done the block returns to idle before the next beat is taken. The
// scan uses one table memory with a single registered read port, one entry
// read and compared at a time.
// Reset empties the set (count to zero); table contents are not cleared,
// since only entries below the count are ever read.
module held_key_set_tracker_top #(
  parameter int TABLE_CAPACITY = hkst_pkg::TABLE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [7:0] key_code,
  output logic       done,
  output logic       is_repeat,
  output logic       was_held,
  output logic [3:0] held_count
);
  import hkst_pkg::*;

  hkst_cmd_t    cmd;
  hkst_status_t st;

  // sequencer: scan, hit/miss decision, swap-remove, append
  hkst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // table memory, count, scan index, result flags
  hkst_datapath #(
    .TABLE_CAPACITY (TABLE_CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .key_code   (key_code),
    .cmd        (cmd),
    .st         (st),
    .is_repeat  (is_repeat),
    .was_held   (was_held),
    .held_count (held_count)
  );

endmodule

@@ rtl/core/hkst_datapath.sv @@
module hkst_datapath #(
  parameter int TABLE_CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         op,
  input  logic [7:0]         key_code,
  input  hkst_pkg::hkst_cmd_t    cmd,
  output hkst_pkg::hkst_status_t st,
  output logic               is_repeat,
  output logic               was_held,
  output logic [3:0]         held_count
);
  import hkst_pkg::*;

  localparam int IDX_W = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);

  logic [7:0]       mem [TABLE_CAPACITY];
  logic [7:0]       rd_data;
  logic [7:0]       code_r;
  logic [1:0]       op_r;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic             full;

  assign full     = (count == CNT_W'(TABLE_CAPACITY));
  assign count_m1 = count - CNT_W'(1);

  assign st.is_press   = (op_r == OP_PRESS);
  assign st.count_zero = (count == '0);
  assign st.match      = (rd_data == code_r);
  assign st.at_last    = ((CNT_W'(idx) + CNT_W'(1)) == count);

  assign held_count = 4'(count);

  // table storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      mem[idx] <= rd_data;
    end else if (cmd.append && !full) begin
      mem[count[IDX_W-1:0]] <= code_r;
    end
    if (cmd.rd_scan) begin
      rd_data <= mem[idx];
    end else if (cmd.rd_last) begin
      rd_data <= mem[count_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      code_r <= key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      is_repeat <= 1'b0;
      was_held  <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx       <= '0;
        is_repeat <= 1'b0;
        was_held  <= 1'b0;
      end else if (cmd.next_idx) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.set_repeat) begin
        is_repeat <= 1'b1;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.move) begin
        count    <= count_m1;
        was_held <= 1'b1;
      end else if (cmd.append && !full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/hkst_ctrl.sv @@
module hkst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            op,
  input  hkst_pkg::hkst_status_t st,
  output hkst_pkg::hkst_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);
  import hkst_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_CMP    = 6'b000100,
    S_MOVE   = 6'b001000,
    S_APPEND = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (op == OP_CLEAR) begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end else if (op == OP_PRESS || op == OP_RELEASE) begin
            if (!st.count_zero) begin
              state_next = S_READ;
            end else if (op == OP_PRESS) begin
              state_next = S_APPEND;
            end else begin
              state_next = S_DONE;
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        if (st.match) begin
          if (st.is_press) begin
            cmd.set_repeat = 1'b1;
            state_next     = S_DONE;
          end else begin
            cmd.rd_last = 1'b1;
            state_next  = S_MOVE;
          end
        end else if (st.at_last) begin
          state_next = st.is_press ? S_APPEND : S_DONE;
        end else begin
          cmd.next_idx = 1'b1;
          state_next   = S_READ;
        end
      end
      S_MOVE: begin
        cmd.move   = 1'b1;
        state_next = S_DONE;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/hkst_checker.sv @@
module hkst_checker #(
  parameter int CAP = 8
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       done,
  input logic       is_repeat,
  input logic       was_held,
  input logic [3:0] held_count
);
  import hkst_pkg::*;

  // result beat only goes out while a beat is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_CLEAR) |=> (done && held_count == 4'd0))
    else $error("clear result wrong");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> ((CAP > 15) || (held_count <= 4'(CAP)))
      && !(is_repeat && was_held))
    else $error("bad result flags or count");

endmodule

bind held_key_set_tracker_top hkst_checker #(
  .CAP (TABLE_CAPACITY)
) u_hkst_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .op         (op),
  .done       (done),
  .is_repeat  (is_repeat),
  .was_held   (was_held),
  .held_count (held_count)
);
